@@ hdl/atg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atg_pkg
// Shared constants and the arctangent table for the tilt / gyro rate unit.
// ----------------------------------------------------------------------------
package atg_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ATAN_TABLE_LEN      = 24;

    localparam logic [12:0] ANGLE_OFFSET_RESET = 13'd1024;

    // register word index on the APB port
    localparam logic REG_ANGLE_OFFSET = 1'b0;

    // isqrt of a 64-bit radicand: one result bit per stage
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_REM_W = 34;

    // CORDIC datapath widths
    localparam int CRD_XW = 36;
    localparam int CRD_ZW = 33;

    localparam logic [30:0] QUARTER_TURN_Q30 = 31'd1686629713;

    // degree conversion: q = round(mag * 180000 * 2^F / (3142 * 2^30))
    localparam int DEG_NUM   = 180000;
    localparam int DEG_DIV   = 3142;
    localparam int DEG_HALF  = 1571;
    localparam int DEG_RECIP = 1366953;    // floor(2^32 / 3142)

    // gyro rate: q = floor((|g| * 2^(F+2) + 131) / 262)
    localparam int RATE_DIV   = 262;
    localparam int RATE_HALF  = 131;
    localparam int RATE_RECIP = 16393004;  // floor(2^32 / 262)

    localparam int RECIP_SHIFT = 32;

    localparam int TILT_MAX = 32767;
    localparam int TILT_MIN = -32768;
    localparam int RATE_MAX = 131071;
    localparam int RATE_MIN = -131072;

    typedef logic [15:0] t_sample;

    function automatic logic [31:0] atg_atan(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'd843314857;
            1:  v = 32'd497837829;
            2:  v = 32'd263043837;
            3:  v = 32'd133525159;
            4:  v = 32'd67021687;
            5:  v = 32'd33543516;
            6:  v = 32'd16775851;
            7:  v = 32'd8388437;
            8:  v = 32'd4194283;
            9:  v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hdl/atg_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atg_isqrt
// Pipelined restoring square root of (sq * 2^32), one root bit per stage.
// ----------------------------------------------------------------------------
module atg_isqrt import atg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire logic [31:0]       i_sq,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_vld,
    output logic [31:0]            o_root,
    output logic [SIDE_W-1:0]      o_side
);

    logic [SQRT_REM_W-1:0] s_rem  [0:SQRT_STEPS];
    logic [31:0]           s_root [0:SQRT_STEPS];
    logic [31:0]           s_sq   [0:SQRT_STEPS];
    logic [SIDE_W-1:0]     s_side [0:SQRT_STEPS];
    logic                  s_vld  [0:SQRT_STEPS];

    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_sq[0]   = i_sq;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_vld;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        logic [1:0]            pair;
        logic [35:0]           acc;
        logic [35:0]           trial;
        logic [SQRT_REM_W-1:0] n_rem;
        logic [31:0]           n_root;
        logic [SQRT_REM_W-1:0] r_rem;
        logic [31:0]           r_root;
        logic [31:0]           r_sq;
        logic [SIDE_W-1:0]     r_side;
        logic                  r_vld;

        // radicand is {sq, 32'b0}: the low half brings in zero pairs
        if (g < 16) begin : g_hi
            assign pair = s_sq[g][31-2*g -: 2];
        end else begin : g_lo
            assign pair = 2'b00;
        end

        always_comb begin
            acc   = {s_rem[g], pair};
            trial = {2'b00, s_root[g], 2'b01};
            if (acc >= trial) begin
                n_rem  = SQRT_REM_W'(acc - trial);
                n_root = {s_root[g][30:0], 1'b1};
            end else begin
                n_rem  = acc[SQRT_REM_W-1:0];
                n_root = {s_root[g][30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_sq   <= s_sq[g];
                r_side <= s_side[g];
            end
        end

        assign s_rem[g+1]  = r_rem;
        assign s_root[g+1] = r_root;
        assign s_sq[g+1]   = r_sq;
        assign s_side[g+1] = r_side;
        assign s_vld[g+1]  = r_vld;
    end

    assign o_vld  = s_vld[SQRT_STEPS];
    assign o_root = s_root[SQRT_STEPS];
    assign o_side = s_side[SQRT_STEPS];

endmodule
`default_nettype wire

@@ hdl/atg_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// atg_cordic
// Unrolled vectoring CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module atg_cordic import atg_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter int SIDE_W = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic signed [CRD_XW-1:0] i_x,
    input  wire logic signed [CRD_XW-1:0] i_y,
    input  wire logic [SIDE_W-1:0]        i_side,
    output logic                          o_vld,
    output logic signed [CRD_ZW-1:0]      o_z,
    output logic [SIDE_W-1:0]             o_side
);

    logic signed [CRD_XW-1:0] s_x    [0:STAGES];
    logic signed [CRD_XW-1:0] s_y    [0:STAGES];
    logic signed [CRD_ZW-1:0] s_z    [0:STAGES];
    logic [SIDE_W-1:0]        s_side [0:STAGES];
    logic                     s_vld  [0:STAGES];

    assign s_x[0]    = i_x;
    assign s_y[0]    = i_y;
    assign s_z[0]    = '0;
    assign s_side[0] = i_side;
    assign s_vld[0]  = i_vld;

    for (genvar g = 0; g < STAGES; g++) begin : g_rot
        localparam logic signed [CRD_ZW-1:0] ATAN = CRD_ZW'(atg_atan(g));
        logic signed [CRD_XW-1:0] dx;
        logic signed [CRD_XW-1:0] dy;
        logic signed [CRD_XW-1:0] r_x;
        logic signed [CRD_XW-1:0] r_y;
        logic signed [CRD_ZW-1:0] r_z;
        logic [SIDE_W-1:0]        r_side;
        logic                     r_vld;

        assign dx = s_y[g] >>> g;
        assign dy = s_x[g] >>> g;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_y[g][CRD_XW-1]) begin
                    r_x <= s_x[g] + dx;
                    r_y <= s_y[g] - dy;
                    r_z <= s_z[g] + ATAN;
                end else begin
                    r_x <= s_x[g] - dx;
                    r_y <= s_y[g] + dy;
                    r_z <= s_z[g] - ATAN;
                end
                r_side <= s_side[g];
            end
        end

        assign s_x[g+1]    = r_x;
        assign s_y[g+1]    = r_y;
        assign s_z[g+1]    = r_z;
        assign s_side[g+1] = r_side;
        assign s_vld[g+1]  = r_vld;
    end

    assign o_vld  = s_vld[STAGES];
    assign o_z    = s_z[STAGES];
    assign o_side = s_side[STAGES];

endmodule
`default_nettype wire

@@ hdl/accel_tilt_and_gyro_rate_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_and_gyro_rate_unit
// Tilt angle from an accelerometer triple and turn rate from one gyro axis.
// ----------------------------------------------------------------------------
// One sample enters per clock while the output is not stalled. Each result
// passes through a register for the squares, 32 square-root stages, one
// stage per CORDIC rotation and four for scaling, rounding and saturation,
// the last being the output register. A stall on the output holds the whole
// pipeline in place, so o_stall follows i_stall while a result is waiting.
// Angles are in 2^-ANGLE_FRAC_BITS degree, rates in 2^-ANGLE_FRAC_BITS deg/s.
module accel_tilt_and_gyro_rate_unit import atg_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [15:0] i_accel_x,
    input  wire logic signed [15:0] i_accel_y,
    input  wire logic signed [15:0] i_accel_z,
    input  wire logic signed [15:0] i_gyro_x,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [15:0]      o_tilt_angle,
    output logic signed [17:0]      o_turn_rate,
    output logic                    o_angle_invalid,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int F    = ANGLE_FRAC_BITS;
    localparam int P1W  = 49;                 // 31-bit magnitude * 180000
    localparam int TW   = 20 + F;             // scaled angle before divide
    localparam int P2W  = TW + 21;
    localparam int QW   = P2W - RECIP_SHIFT;
    localparam int AW   = QW + 8;
    localparam int NW   = F + 19;             // rate numerator
    localparam int P3W  = NW + 24;
    localparam int GQW  = P3W - RECIP_SHIFT;
    localparam int RSW  = GQW + 2;
    localparam int SQ_SIDE_W  = 34;           // {accel_y, gyro, quarter, invalid}
    localparam int CRD_SIDE_W = 19;           // {y_neg, gyro, quarter, invalid}

    // ---------------- configuration ----------------
    logic [12:0] r_angle_offset;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_offset <= ANGLE_OFFSET_RESET;
        end else if (cfg_wr && (paddr[2] == REG_ANGLE_OFFSET)) begin
            r_angle_offset <= pwdata[12:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_ANGLE_OFFSET) begin
            prdata = 32'($signed(r_angle_offset));
        end else begin
            prdata = '0;
        end
    end

    // ---------------- pipeline enable ----------------
    logic en;
    logic r_o_vld;

    assign o_stall = r_o_vld && i_stall;
    assign en      = !o_stall;

    // ---------------- stage 0: squares ----------------
    logic signed [31:0]     xx;
    logic signed [31:0]     zz;
    logic                   r_s0_vld;
    logic [31:0]            r_s0_sq;
    logic [SQ_SIDE_W-1:0]   r_s0_side;
    logic                   in_quarter;
    logic                   in_invalid;

    assign xx = i_accel_x * i_accel_x;
    assign zz = i_accel_z * i_accel_z;
    assign in_quarter = (i_accel_x == 16'sd0) && (i_accel_z == 16'sd0);
    assign in_invalid = in_quarter && (i_accel_y == 16'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_sq   <= {1'b0, xx[30:0]} + {1'b0, zz[30:0]};
            r_s0_side <= {i_accel_y, i_gyro_x, in_quarter, in_invalid};
        end
    end

    // ---------------- square root ----------------
    logic                 sq_vld;
    logic [31:0]          sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    atg_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s0_vld),
        .i_sq    (r_s0_sq),
        .i_side  (r_s0_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- CORDIC ----------------
    logic [15:0]               sq_ay;
    logic [16:0]               ay_abs;
    logic signed [CRD_XW-1:0]  crd_x;
    logic signed [CRD_XW-1:0]  crd_y;
    logic [CRD_SIDE_W-1:0]     crd_side_in;
    logic                      crd_vld;
    logic signed [CRD_ZW-1:0]  crd_z;
    logic [CRD_SIDE_W-1:0]     crd_side;

    assign sq_ay  = sq_side[33:18];
    assign ay_abs = sq_ay[15] ? (17'd0 - {1'b1, sq_ay}) : {1'b0, sq_ay};
    assign crd_x  = CRD_XW'({1'b0, sq_root});
    assign crd_y  = CRD_XW'({1'b0, ay_abs, 16'd0});
    assign crd_side_in = {sq_ay[15], sq_side[17:0]};

    atg_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W (CRD_SIDE_W)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_x     (crd_x),
        .i_y     (crd_y),
        .i_side  (crd_side_in),
        .o_vld   (crd_vld),
        .o_z     (crd_z),
        .o_side  (crd_side)
    );

    // ---------------- D1: magnitude and first products ----------------
    logic                     c_yneg;
    logic [15:0]              c_gx;
    logic                     c_quarter;
    logic                     c_inv;
    logic [CRD_ZW-1:0]        z_abs;
    logic [30:0]              mag;
    logic [16:0]              g_abs;

    assign c_yneg    = crd_side[18];
    assign c_gx      = crd_side[17:2];
    assign c_quarter = crd_side[1];
    assign c_inv     = crd_side[0];
    assign z_abs     = crd_z[CRD_ZW-1] ? CRD_ZW'(-crd_z) : CRD_ZW'(crd_z);
    assign mag       = c_quarter ? QUARTER_TURN_Q30 : z_abs[30:0];
    assign g_abs     = c_gx[15] ? (17'd0 - {1'b1, c_gx}) : {1'b0, c_gx};

    logic           r_d1_vld;
    logic [P1W-1:0] r_d1_prod;
    logic           r_d1_neg;
    logic           r_d1_inv;
    logic [NW-1:0]  r_d1_gnum;
    logic           r_d1_gneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld <= 1'b0;
        end else if (en) begin
            r_d1_vld <= crd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_prod <= P1W'(mag) * P1W'(DEG_NUM);
            r_d1_neg  <= c_quarter ? c_yneg : (crd_z[CRD_ZW-1] ^ c_yneg);
            r_d1_inv  <= c_inv;
            r_d1_gnum <= (NW'(g_abs) << (F + 2)) + NW'(RATE_HALF);
            r_d1_gneg <= c_gx[15];
        end
    end

    // ---------------- D2: reciprocal multiplies ----------------
    logic [TW-1:0]  t_val;
    logic [P2W-1:0] p2;
    logic [P3W-1:0] p3;

    assign t_val = TW'(r_d1_prod >> (30 - F)) + TW'(DEG_HALF);
    assign p2    = P2W'(t_val) * P2W'(DEG_RECIP);
    assign p3    = P3W'(r_d1_gnum) * P3W'(RATE_RECIP);

    logic            r_d2_vld;
    logic [TW-1:0]   r_d2_t;
    logic [QW-1:0]   r_d2_qa;
    logic            r_d2_neg;
    logic            r_d2_inv;
    logic [NW-1:0]   r_d2_gnum;
    logic [GQW-1:0]  r_d2_gq;
    logic            r_d2_gneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_vld <= 1'b0;
        end else if (en) begin
            r_d2_vld <= r_d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_t    <= t_val;
            r_d2_qa   <= p2[P2W-1:RECIP_SHIFT];
            r_d2_neg  <= r_d1_neg;
            r_d2_inv  <= r_d1_inv;
            r_d2_gnum <= r_d1_gnum;
            r_d2_gq   <= p3[P3W-1:RECIP_SHIFT];
            r_d2_gneg <= r_d1_gneg;
        end
    end

    // ---------------- D3: quotient correction ----------------
    // the reciprocal estimate is low by at most one
    logic [TW:0] rem_a;
    logic [NW:0] rem_g;

    assign rem_a = (TW+1)'(r_d2_t) - (TW+1)'(r_d2_qa) * (TW+1)'(DEG_DIV);
    assign rem_g = (NW+1)'(r_d2_gnum) - (NW+1)'(r_d2_gq) * (NW+1)'(RATE_DIV);

    logic           r_d3_vld;
    logic [QW-1:0]  r_d3_qa;
    logic           r_d3_neg;
    logic           r_d3_inv;
    logic [GQW-1:0] r_d3_gq;
    logic           r_d3_gneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d3_vld <= 1'b0;
        end else if (en) begin
            r_d3_vld <= r_d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d3_qa   <= (rem_a >= (TW+1)'(DEG_DIV)) ? r_d2_qa + QW'(1) : r_d2_qa;
            r_d3_gq   <= (rem_g >= (NW+1)'(RATE_DIV)) ? r_d2_gq + GQW'(1) : r_d2_gq;
            r_d3_neg  <= r_d2_neg;
            r_d3_inv  <= r_d2_inv;
            r_d3_gneg <= r_d2_gneg;
        end
    end

    // ---------------- D4: sign, offset, saturation ----------------
    logic signed [AW-1:0]  qa_ext;
    logic signed [AW-1:0]  qa_sgn;
    logic signed [AW-1:0]  tilt_sum;
    logic signed [15:0]    tilt_sat;
    logic signed [RSW-1:0] gq_ext;
    logic signed [RSW-1:0] rate_sgn;
    logic signed [17:0]    rate_sat;

    assign qa_ext   = AW'(signed'({1'b0, r_d3_qa}));
    assign qa_sgn   = r_d3_neg ? -qa_ext : qa_ext;
    assign tilt_sum = qa_sgn + AW'($signed(r_angle_offset));
    assign gq_ext   = RSW'(signed'({1'b0, r_d3_gq}));
    assign rate_sgn = r_d3_gneg ? -gq_ext : gq_ext;

    always_comb begin
        priority if (tilt_sum > TILT_MAX) begin
            tilt_sat = 16'sh7FFF;
        end else if (tilt_sum < TILT_MIN) begin
            tilt_sat = -16'sh8000;
        end else begin
            tilt_sat = tilt_sum[15:0];
        end
        priority if (rate_sgn > RATE_MAX) begin
            rate_sat = 18'sh1FFFF;
        end else if (rate_sgn < RATE_MIN) begin
            rate_sat = -18'sh20000;
        end else begin
            rate_sat = rate_sgn[17:0];
        end
    end

    logic signed [15:0] r_tilt;
    logic signed [17:0] r_rate;
    logic               r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_d3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tilt <= r_d3_inv ? 16'sd0 : tilt_sat;
            r_rate <= rate_sat;
            r_inv  <= r_d3_inv;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_tilt_angle    = r_tilt;
    assign o_turn_rate     = r_rate;
    assign o_angle_invalid = r_inv;

    // ---------------- assertions ----------------
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_angle_invalid |-> o_tilt_angle == 16'sd0)
        else $error("flagged sample carries a nonzero angle");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled with no result waiting");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_d3_vld) && $stable(r_d1_vld))
        else $error("pipeline advanced during a stall");

endmodule
`default_nettype wire
